>>> design/alpha_over_blend_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the alpha-over blend core
// Shared helpers that wrap clocked concurrent assertions with reset gating.
// ----------------------------------------------------------------------------
`ifndef ALPHA_OVER_BLEND_CORE_DEFINES_SVH
`define ALPHA_OVER_BLEND_CORE_DEFINES_SVH

// Property checked on every rising edge of clk, ignored while rst is high.
`define AOB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, but the property is a plain implication written by the caller.
`define AOB_ASSERT_IMPL(lbl, lhs, rhs, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

`endif

>>> design/alob_pkg.sv
// ----------------------------------------------------------------------------
// Alpha-over blend package
// Shared types, format codes and helpers for the blend core and its lanes.
// ----------------------------------------------------------------------------
package alob_pkg;

  localparam int FG_FRAC_BITS_DEF = 15;
  localparam int DIV_STEPS        = 8;
  localparam int LANE_LAT         = 3 + DIV_STEPS;

  typedef enum logic [1:0] {
    FMT_GRAY   = 2'd0,
    FMT_GRAY_A = 2'd1,
    FMT_RGB    = 2'd2,
    FMT_RGBA   = 2'd3
  } fmt_t;

  typedef struct packed {
    logic [15:0] fg_red;
    logic [15:0] fg_green;
    logic [15:0] fg_blue;
    logic [15:0] fg_opacity;
    logic [7:0]  bg_red;
    logic [7:0]  bg_green;
    logic [7:0]  bg_blue;
    logic [7:0]  bg_opacity;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_opacity;
  } blend_t;

  typedef struct packed {
    logic over;
    logic alpha_mode;
    logic opaque;
    logic trunc;
  } lane_ctl_t;

  function automatic logic [7:0] sat8(input logic [24:0] v);
    return (v > 25'd255) ? 8'hFF : v[7:0];
  endfunction

endpackage

>>> design/alob_lane.sv
// ----------------------------------------------------------------------------
// Blend lane
// One colour component: scale, interpolate and over-composite with a
// pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module alob_lane #(
  parameter int FB = alob_pkg::FG_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  alob_pkg::lane_ctl_t  ctl,
  input  logic [15:0]          f,
  input  logic [15:0]          a,
  input  logic [7:0]           c,
  input  logic [7:0]           b,
  input  logic [FB+7:0]        gm,
  output logic [7:0]           colour
);
  import alob_pkg::*;

  localparam int GW = FB + 8;
  localparam int TW = ((FB + 8 > 24) ? FB + 8 : 24) + 2;
  localparam int XW = TW + 19;
  localparam int NW = ((2 * FB + 17 > 48) ? 2 * FB + 17 : 48) + 2;
  localparam int K  = 2 * FB + 1;
  localparam logic signed [XW-1:0] DHALF = XW'(1) <<< (2 * FB);
  localparam logic signed [XW-1:0] BIAS  = (XW'(1) <<< K) - XW'(1);

  // stage 1
  logic [FB:0]            sa_c;
  logic [23:0]            f255_c;
  logic signed [TW-1:0]   t_c;
  logic [15:0]            cb1;
  logic [31:0]            fa1;
  logic [FB:0]            sa1;
  logic signed [TW-1:0]   t1;
  logic [15:0]            a1;
  logic [7:0]             c1, sc1, st1;
  lane_ctl_t              ctl1;

  always_comb begin
    sa_c   = (FB+1)'(1 << FB) - (FB+1)'(a);
    f255_c = {f, 8'd0} - 24'(f);
    t_c    = $signed(TW'(f255_c)) - $signed(TW'(c) << FB);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cb1  <= c * b;
      fa1  <= f * a;
      sa1  <= sa_c;
      t1   <= t_c;
      a1   <= a;
      c1   <= c;
      sc1  <= sat8((25'(f255_c) + 25'(1 << (FB - 1))) >> FB);
      st1  <= sat8(25'(f255_c) >> FB);
      ctl1 <= ctl;
    end
  end

  // stage 2
  logic [FB+16:0]         cbs2;
  logic [47:0]            ffa2;
  logic signed [TW+16:0]  n2;
  logic [GW-1:0]          g2;
  logic [7:0]             c2, sc2, st2;
  lane_ctl_t              ctl2;

  always_ff @(posedge clk) begin
    if (en) begin
      cbs2 <= cb1 * sa1;
      // 65025 = 65536 - 512 + 1
      ffa2 <= (48'(fa1) << 16) - (48'(fa1) << 9) + 48'(fa1);
      n2   <= t1 * $signed({1'b0, a1});
      g2   <= gm;
      c2   <= c1;
      sc2  <= sc1;
      st2  <= st1;
      ctl2 <= ctl1;
    end
  end

  // stage 3: over numerator, interpolation with round toward zero
  logic [NW-1:0]          num_c;
  logic signed [XW-1:0]   x_c, y_c, q_c, r_c;
  logic [7:0]             lerp_c, alt_c;
  logic [NW-1:0]          num3;
  logic [GW-1:0]          g3;
  logic [7:0]             alt3;
  logic                   over3;

  always_comb begin
    num_c  = (NW'(cbs2) << FB) + NW'(ffa2) + (NW'(g2) << (FB - 1));
    x_c    = (XW'(n2) <<< 1) + DHALF;
    y_c    = x_c + (x_c[XW-1] ? BIAS : '0);
    q_c    = y_c >>> K;
    r_c    = q_c + $signed(XW'({1'b0, c2}));
    if (r_c[XW-1]) begin
      lerp_c = 8'd0;
    end else if (r_c > $signed(XW'(255))) begin
      lerp_c = 8'hFF;
    end else begin
      lerp_c = r_c[7:0];
    end
    if (ctl2.alpha_mode) begin
      alt_c = sc2;
    end else if (ctl2.opaque) begin
      alt_c = ctl2.trunc ? st2 : sc2;
    end else begin
      alt_c = lerp_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num3  <= num_c;
      g3    <= g2;
      alt3  <= alt_c;
      over3 <= ctl2.over;
    end
  end

  // divider: saturate check in the first step, and one quotient bit a stage
  logic [NW-1:0] drem [DIV_STEPS-1];
  logic [GW-1:0] dg   [DIV_STEPS-1];
  logic [7:0]    dq   [DIV_STEPS];
  logic          dsat [DIV_STEPS];
  logic [7:0]    dalt [DIV_STEPS];
  logic          dover[DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [NW-1:0] rin, sub;
    logic [GW-1:0] gin;
    logic [7:0]    qin, qnx;
    logic          sin, ain_over, ge;
    logic [7:0]    ain;

    if (j == 0) begin : g_first
      always_comb begin
        rin      = num3;
        gin      = g3;
        qin      = 8'd0;
        sin      = num3 >= (NW'(g3) << (FB + 8));
        ain      = alt3;
        ain_over = over3;
      end
    end else begin : g_rest
      always_comb begin
        rin      = drem[j-1];
        gin      = dg[j-1];
        qin      = dq[j-1];
        sin      = dsat[j-1];
        ain      = dalt[j-1];
        ain_over = dover[j-1];
      end
    end

    always_comb begin
      sub          = NW'(gin) << (FB + 7 - j);
      ge           = rin >= sub;
      qnx          = qin;
      qnx[7-j]     = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dq[j]    <= qnx;
        dsat[j]  <= sin;
        dalt[j]  <= ain;
        dover[j] <= ain_over;
      end
    end

    if (j < DIV_STEPS - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          drem[j] <= ge ? rin - sub : rin;
          dg[j]   <= gin;
        end
      end
    end
  end

  assign colour = dover[DIV_STEPS-1]
                ? (dsat[DIV_STEPS-1] ? 8'hFF : dq[DIV_STEPS-1])
                : dalt[DIV_STEPS-1];

endmodule

>>> design/alob_merge.sv
// ----------------------------------------------------------------------------
// Blend merge stage
// Gathers the lane results and alpha, clears unused bytes, holds the result.
// ----------------------------------------------------------------------------
module alob_merge (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vin,
  input  alob_pkg::fmt_t    fmt,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  input  logic [7:0]        alpha,
  output logic              blend_valid,
  output alob_pkg::blend_t  blend
);
  import alob_pkg::*;

  blend_t blend_next;

  always_comb begin
    blend_next = '0;
    blend_next.out_red = red;
    unique case (fmt)
      FMT_GRAY: begin
      end
      FMT_GRAY_A: begin
        blend_next.out_opacity = alpha;
      end
      FMT_RGB: begin
        blend_next.out_green = green;
        blend_next.out_blue  = blue;
      end
      FMT_RGBA: begin
        blend_next.out_green   = green;
        blend_next.out_blue    = blue;
        blend_next.out_opacity = alpha;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_valid <= 1'b0;
    end else if (en) begin
      blend_valid <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blend <= blend_next;
    end
  end

endmodule

>>> design/alpha_over_blend_core.sv
// ----------------------------------------------------------------------------
// Alpha-over blend core
// Composites a fixed-point foreground pixel over an 8-bit background pixel.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock and returns one blended pixel per clock
// when the output side keeps up. The whole pipeline holds while a finished
// result is not taken. Each result passes the request register, three lane
// stages and the eight-stage divider in each of the three colour lanes, then
// the merge register. The format register may be written only while no pixel
// is in flight.
`include "alpha_over_blend_core_defines.svh"

module alpha_over_blend_core #(
  parameter int FG_FRAC_BITS = alob_pkg::FG_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data,
  input  logic              pixel_valid,
  output logic              pixel_ready,
  input  alob_pkg::pixel_t  pixel,
  output logic              blend_valid,
  input  logic              blend_ready,
  output alob_pkg::blend_t  blend
);
  import alob_pkg::*;

  localparam int FB = FG_FRAC_BITS;
  localparam int GW = FB + 8;
  localparam int OW = ((FB + 10 > 26) ? FB + 10 : 26) + 1;

  fmt_t pixel_format;
  logic en;

  assign cfg_ready   = 1'b1;
  assign en          = !blend_valid || blend_ready;
  assign pixel_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_RGBA;
    end else if (cfg_valid) begin
      pixel_format <= fmt_t'(cfg_data);
    end
  end

  // request register and valid line
  logic [LANE_LAT:0] vld;
  pixel_t            pix0;
  fmt_t              fmt0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LANE_LAT-1:0], pixel_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix0 <= pixel;
      fmt0 <= pixel_format;
    end
  end

  // per-pixel controls and shared gamma
  logic            op0, amode0;
  lane_ctl_t       ctl0;
  logic [FB:0]     sa0;
  logic [GW-1:0]   gm0;
  logic [23:0]     a255;
  logic [7:0]      ascale0;

  always_comb begin
    op0    = (OW'(pix0.fg_opacity) * OW'(1000)) > (OW'(996) << FB);
    amode0 = (fmt0 == FMT_GRAY_A) || (fmt0 == FMT_RGBA);
    ctl0.over       = amode0 && (pix0.bg_opacity != 8'd0) && !op0;
    ctl0.alpha_mode = amode0;
    ctl0.opaque     = op0;
    ctl0.trunc      = (fmt0 == FMT_GRAY);
    sa0     = (FB+1)'(1 << FB) - (FB+1)'(pix0.fg_opacity);
    gm0     = GW'(sa0) * GW'(pix0.bg_opacity)
            + (GW'(pix0.fg_opacity) << 8) - GW'(pix0.fg_opacity);
    a255    = {pix0.fg_opacity, 8'd0} - 24'(pix0.fg_opacity);
    ascale0 = sat8((25'(a255) + 25'(1 << (FB - 1))) >> FB);
  end

  logic [GW-1:0] g1;
  logic [7:0]    as1;
  logic          over1;
  fmt_t          fmt1;

  always_ff @(posedge clk) begin
    if (en) begin
      g1    <= gm0;
      as1   <= ascale0;
      over1 <= ctl0.over;
      fmt1  <= fmt0;
    end
  end

  // result alpha, then delay it and the format alongside the lanes
  logic [GW:0] grnd, gsh;
  logic [7:0]  abyte;

  always_comb begin
    grnd  = (GW+1)'(g1) + (GW+1)'(1 << (FB - 1));
    gsh   = grnd >> FB;
    abyte = over1 ? ((gsh > (GW+1)'(255)) ? 8'hFF : gsh[7:0]) : as1;
  end

  logic [7:0] aline [LANE_LAT-1];
  fmt_t       fline [LANE_LAT-1];

  for (genvar i = 0; i < LANE_LAT - 1; i++) begin : g_aline
    always_ff @(posedge clk) begin
      if (en) begin
        if (i == 0) begin
          aline[i] <= abyte;
          fline[i] <= fmt1;
        end else begin
          aline[i] <= aline[(i == 0) ? 0 : i - 1];
          fline[i] <= fline[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  logic [7:0] red_l, green_l, blue_l;

  alob_lane #(.FB(FB)) u_lane_red (
    .clk    (clk),
    .en     (en),
    .ctl    (ctl0),
    .f      (pix0.fg_red),
    .a      (pix0.fg_opacity),
    .c      (pix0.bg_red),
    .b      (pix0.bg_opacity),
    .gm     (g1),
    .colour (red_l)
  );

  alob_lane #(.FB(FB)) u_lane_green (
    .clk    (clk),
    .en     (en),
    .ctl    (ctl0),
    .f      (pix0.fg_green),
    .a      (pix0.fg_opacity),
    .c      (pix0.bg_green),
    .b      (pix0.bg_opacity),
    .gm     (g1),
    .colour (green_l)
  );

  alob_lane #(.FB(FB)) u_lane_blue (
    .clk    (clk),
    .en     (en),
    .ctl    (ctl0),
    .f      (pix0.fg_blue),
    .a      (pix0.fg_opacity),
    .c      (pix0.bg_blue),
    .b      (pix0.bg_opacity),
    .gm     (g1),
    .colour (blue_l)
  );

  alob_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .vin         (vld[LANE_LAT]),
    .fmt         (fline[LANE_LAT-2]),
    .red         (red_l),
    .green       (green_l),
    .blue        (blue_l),
    .alpha       (aline[LANE_LAT-2]),
    .blend_valid (blend_valid),
    .blend       (blend)
  );

  `AOB_ASSERT_IMPL(a_stall_blocks_req, blend_valid && !blend_ready, !pixel_ready, "req in stall")
  `AOB_ASSERT(a_req_enters_pipe, (pixel_valid && pixel_ready) |=> vld[0], "request lost")
  `AOB_ASSERT(a_drop_only_on_take, $fell(blend_valid) |-> $past(blend_ready), "result dropped")

endmodule

>>> tb/alpha_over_blend_core_tb.sv
// ----------------------------------------------------------------------------
// Alpha-over blend core testbench
// Sends pixel requests through a short table and then a long random run in
// all four formats. Each result is checked against a hand-written value or a
// fixed-point prediction while the sides idle and stall at random by phase.
// ----------------------------------------------------------------------------
module alpha_over_blend_core_tb;
  import alob_pkg::*;

  localparam longint ONE      = 64'd1 << FG_FRAC_BITS_DEF;
  localparam int     DRAIN    = LANE_LAT + 8;
  localparam int     WD_LIMIT = 4000;

  typedef struct {
    fmt_t   fmt;
    pixel_t px;
    bit     known;
    blend_t res;
  } row_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  logic   [1:0] cfg_data = 2'd0;
  logic   pixel_valid = 1'b0;
  logic   pixel_ready;
  pixel_t pixel = '0;
  logic   blend_valid;
  logic   blend_ready = 1'b0;
  blend_t blend;

  fmt_t   cur_fmt = FMT_RGBA;
  blend_t blend_q[$];
  row_t   rows[$];
  int     send_idle = 0;
  int     recv_stall = 0;
  int     errors = 0;
  int     n_results = 0;
  int     quiet = 0;
  int     fmt_hits[4] = '{0, 0, 0, 0};

  always #1 clk = ~clk;

  alpha_over_blend_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .blend_valid (blend_valid),
    .blend_ready (blend_ready),
    .blend       (blend)
  );

  function automatic logic [7:0] clamp8(longint v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic logic [7:0] scaled_fg(longint f);
    return clamp8((255 * f + ONE / 2) >>> FG_FRAC_BITS_DEF);
  endfunction

  function automatic logic [7:0] over_mix(longint f, longint c, longint a, longint b,
                                          longint gam);
    longint unsigned den, num;
    den = ONE * gam;
    num = c * b * (ONE - a) * ONE + 65025 * f * a + den / 2;
    return clamp8(num / den);
  endfunction

  // Signed division truncates toward zero, as the interpolation wants.
  function automatic logic [7:0] lerp_mix(longint f, longint c, longint a);
    longint n, d, q;
    n = (255 * f - c * ONE) * a;
    d = ONE * ONE;
    q = (2 * n + d) / (2 * d);
    return clamp8(q + c);
  endfunction

  function automatic blend_t blend_predict(fmt_t f, pixel_t p);
    blend_t r;
    longint fa, ba, gam;
    bit     opq;
    r   = '0;
    fa  = p.fg_opacity;
    ba  = p.bg_opacity;
    opq = fa * 1000 > 996 * ONE;
    gam = (ONE - fa) * ba + 255 * fa;
    case (f)
      FMT_GRAY: begin
        if (opq) r.out_red = clamp8((255 * longint'(p.fg_red)) >>> FG_FRAC_BITS_DEF);
        else r.out_red = lerp_mix(p.fg_red, p.bg_red, fa);
      end
      FMT_RGB: begin
        if (opq) begin
          r.out_red   = scaled_fg(p.fg_red);
          r.out_green = scaled_fg(p.fg_green);
          r.out_blue  = scaled_fg(p.fg_blue);
        end else begin
          r.out_red   = lerp_mix(p.fg_red, p.bg_red, fa);
          r.out_green = lerp_mix(p.fg_green, p.bg_green, fa);
          r.out_blue  = lerp_mix(p.fg_blue, p.bg_blue, fa);
        end
      end
      default: begin
        if (ba == 0 || opq) begin
          r.out_red     = scaled_fg(p.fg_red);
          r.out_opacity = scaled_fg(fa);
          if (f == FMT_RGBA) begin
            r.out_green = scaled_fg(p.fg_green);
            r.out_blue  = scaled_fg(p.fg_blue);
          end
        end else begin
          r.out_opacity = clamp8((gam + ONE / 2) / ONE);
          r.out_red     = over_mix(p.fg_red, p.bg_red, fa, ba, gam);
          if (f == FMT_RGBA) begin
            r.out_green = over_mix(p.fg_green, p.bg_green, fa, ba, gam);
            r.out_blue  = over_mix(p.fg_blue, p.bg_blue, fa, ba, gam);
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic add_row(fmt_t f, int fr, int fg, int fb, int fa, int br, int bg,
                         int bb, int ba, bit known = 1'b0, int er = 0, int eg = 0,
                         int eb = 0, int eo = 0);
    row_t w;
    w.fmt   = f;
    w.px    = '{16'(fr), 16'(fg), 16'(fb), 16'(fa), 8'(br), 8'(bg), 8'(bb), 8'(ba)};
    w.known = known;
    w.res   = '{8'(er), 8'(eg), 8'(eb), 8'(eo)};
    rows.push_back(w);
  endtask

  // Write the format only once the pipeline has emptied.
  task automatic set_format(fmt_t f);
    pixel_valid <= 1'b0;
    wait (blend_q.size() == 0);
    repeat (DRAIN) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= f;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_fmt = f;
  endtask

  task automatic send_pixel(pixel_t p, blend_t e);
    while ($urandom_range(99) < send_idle) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    blend_q.push_back(e);
    fmt_hits[cur_fmt]++;
    do @(posedge clk); while (!pixel_ready);
  endtask

  function automatic logic [15:0] rand_frac();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'd32768;
      2:       return 16'($urandom_range(65535));
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  function automatic logic [15:0] rand_alpha();
    case ($urandom_range(9))
      0:       return 16'd0;
      1, 2:    return 16'($urandom_range(32768, 32630));
      3:       return 16'($urandom_range(65535));
      default: return 16'($urandom_range(32636));
    endcase
  endfunction

  function automatic logic [7:0] rand_byte(bit alpha);
    int k;
    k = $urandom_range(9);
    if (alpha && k < 2) return 8'd0;
    if (k == 2) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  // Check every taken result, then pick the next stall.
  always @(posedge clk) begin
    if (!rst && blend_valid && blend_ready) begin
      n_results++;
      if (blend_q.size() == 0) begin
        $error("result with nothing expected: %h", blend);
        errors++;
      end else begin
        blend_t e;
        e = blend_q.pop_front();
        if (blend.out_red !== e.out_red) begin
          $error("out_red: expected %0d, got %0d", e.out_red, blend.out_red);
          errors++;
        end
        if (blend.out_green !== e.out_green) begin
          $error("out_green: expected %0d, got %0d", e.out_green, blend.out_green);
          errors++;
        end
        if (blend.out_blue !== e.out_blue) begin
          $error("out_blue: expected %0d, got %0d", e.out_blue, blend.out_blue);
          errors++;
        end
        if (blend.out_opacity !== e.out_opacity) begin
          $error("out_opacity: expected %0d, got %0d", e.out_opacity, blend.out_opacity);
          errors++;
        end
      end
    end
    blend_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (blend_valid && blend_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WD_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    pixel_t p;
    fmt_t   f;
    int     ph;
    int     k;
    int     idle_sets[4][2] = '{'{0, 0}, '{75, 0}, '{0, 75}, '{31, 31}};

    // Reset format is rgba; then gray, gray+alpha, rgb.
    add_row(FMT_RGBA, 32768, 32768, 32768, 32768, 0, 0, 0, 0, 1, 255, 255, 255, 255);
    add_row(FMT_RGBA, 0, 0, 0, 0, 90, 91, 92, 0, 1, 0, 0, 0, 0);
    add_row(FMT_RGBA, 65535, 65535, 65535, 65535, 255, 255, 255, 255, 1, 255, 255, 255,
            255);
    add_row(FMT_RGBA, 0, 0, 0, 0, 10, 20, 30, 255, 1, 10, 20, 30, 255);
    add_row(FMT_RGBA, 12000, 30000, 65535, 16384, 128, 7, 250, 128);
    add_row(FMT_RGBA, 32768, 0, 20000, 32636, 255, 255, 0, 1);
    add_row(FMT_RGBA, 100, 200, 300, 32637, 255, 255, 255, 200);
    add_row(FMT_GRAY, 32768, 5, 5, 32768, 9, 9, 9, 9, 1, 255, 0, 0, 0);
    add_row(FMT_GRAY, 65535, 0, 0, 65535, 0, 0, 0, 0, 1, 255, 0, 0, 0);
    add_row(FMT_GRAY, 0, 0, 0, 0, 200, 1, 1, 1, 1, 200, 0, 0, 0);
    add_row(FMT_GRAY, 0, 0, 0, 16384, 255, 0, 0, 0);
    add_row(FMT_GRAY, 65535, 0, 0, 32636, 0, 0, 0, 0);
    add_row(FMT_GRAY_A, 16384, 9, 9, 16384, 50, 9, 9, 0, 1, 128, 0, 0, 128);
    add_row(FMT_GRAY_A, 65535, 65535, 65535, 65535, 255, 255, 255, 255, 1, 255, 0, 0, 255);
    add_row(FMT_GRAY_A, 20000, 0, 0, 8000, 77, 0, 0, 60);
    add_row(FMT_GRAY_A, 32768, 0, 0, 1, 255, 0, 0, 255);
    add_row(FMT_RGB, 0, 0, 0, 0, 11, 22, 33, 44, 1, 11, 22, 33, 0);
    add_row(FMT_RGB, 0, 32768, 65535, 32768, 5, 5, 5, 5, 1, 0, 255, 255, 0);
    add_row(FMT_RGB, 16000, 8000, 32768, 20000, 30, 240, 128, 0);
    add_row(FMT_RGB, 65535, 0, 32768, 32636, 0, 255, 0, 255);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].fmt != cur_fmt) set_format(rows[i].fmt);
      send_pixel(rows[i].px,
                 rows[i].known ? rows[i].res : blend_predict(cur_fmt, rows[i].px));
    end

    // Random part: four idling phases, each with six format settings.
    for (ph = 0; ph < 4; ph++) begin
      send_idle  = idle_sets[ph][0];
      recv_stall = idle_sets[ph][1];
      for (int c = 0; c < 6; c++) begin
        f = (c < 4) ? fmt_t'((c + ph) % 4) : fmt_t'($urandom_range(3));
        set_format(f);
        for (k = 0; k < 75; k++) begin
          p.fg_red     = rand_frac();
          p.fg_green   = rand_frac();
          p.fg_blue    = rand_frac();
          p.fg_opacity = rand_alpha();
          p.bg_red     = rand_byte(1'b0);
          p.bg_green   = rand_byte(1'b0);
          p.bg_blue    = rand_byte(1'b0);
          p.bg_opacity = rand_byte(1'b1);
          send_pixel(p, blend_predict(cur_fmt, p));
        end
      end
    end
    pixel_valid <= 1'b0;

    wait (blend_q.size() == 0);
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d results: gray %0d, gray+alpha %0d, rgb %0d, rgba %0d",
             n_results, fmt_hits[0], fmt_hits[1], fmt_hits[2], fmt_hits[3]);
    $display("idling phases: none, sender 75%%, receiver 75%%, both 31%%");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/alob_pkg.sv
design/alob_lane.sv
design/alob_merge.sv
design/alpha_over_blend_core.sv
tb/alpha_over_blend_core_tb.sv
